>>> design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

>>> design/clns_pkg.sv
// Types, codes and command tables for the character LCD nibble sequencer.
// No dependencies; imported by every other design file but assert_macros.svh.
`default_nettype none

package clns_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned OFFSET_W = 7;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned CON_W    = 6;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 6;
  localparam int unsigned STEP_W   = 5;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_INIT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_CMD  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DATA = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ADJ  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_HEX  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CONTRAST   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAVED_CONTRAST = 4'd1;

  localparam logic [CON_W-1:0] MAX_CONTRAST_RST   = 6'd63;
  localparam logic [CON_W-1:0] SAVED_CONTRAST_RST = 6'd32;

  // command bytes
  localparam logic [7:0] CMD_FUNC_EXT   = 8'h29;
  localparam logic [7:0] CMD_BIAS       = 8'h1C;
  localparam logic [7:0] CMD_FOLLOWER   = 8'h6C;
  localparam logic [7:0] CMD_PWR_INIT   = 8'h50;
  localparam logic [7:0] CMD_PWR_ADJ    = 8'h54;
  localparam logic [7:0] CMD_CONTRAST   = 8'h70;
  localparam logic [7:0] CMD_FUNC_STD   = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_ENTRY      = 8'h06;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_HOME_ADDR  = 8'h80;
  localparam logic [NIB_W-1:0] NIB_RESET  = 4'h3;
  localparam logic [NIB_W-1:0] NIB_4BIT   = 4'h2;
  localparam logic [7:0] ASCII_ZERO     = 8'h30;
  localparam logic [7:0] ASCII_LETTER   = 8'h37;
  localparam logic [3:0] DIGIT_MAX      = 4'd9;

  // init sequence: three reset nibbles and a 4-bit mode nibble, then byte pairs
  localparam logic [STEP_W-1:0] INIT_NIBS = 5'd4;
  localparam logic [STEP_W-1:0] LAST_INIT = 5'd25;
  localparam logic [STEP_W-1:0] LAST_BYTE = 5'd1;
  localparam logic [STEP_W-1:0] LAST_ADJ  = 5'd7;
  localparam logic [STEP_W-1:0] LAST_HEX  = 5'd3;
  localparam logic [STEP_W-1:0] LAST_NULL = 5'd0;

  typedef enum logic [2:0] {
    K_INIT,
    K_BYTE,
    K_ADJ,
    K_HEX,
    K_NULL
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic               rs;
    logic [VALUE_W-1:0] data;
    logic [CON_W-1:0]   contrast;
  } desc_t;

  typedef struct packed {
    logic             strobe;
    logic             rs;
    logic [NIB_W-1:0] nibble;
  } nib_t;

  function automatic logic [7:0] init_cmd(logic [3:0] idx, logic [CON_W-1:0] c);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = CMD_FUNC_EXT;
      4'd1:    b = CMD_BIAS;
      4'd2:    b = CMD_FOLLOWER;
      4'd3:    b = CMD_PWR_INIT | {6'd0, c[5:4]};
      4'd4:    b = CMD_CONTRAST | {4'd0, c[3:0]};
      4'd5:    b = CMD_FUNC_STD;
      4'd6:    b = CMD_DISP_OFF;
      4'd7:    b = CMD_CLEAR;
      4'd8:    b = CMD_ENTRY;
      4'd9:    b = CMD_DISP_ON;
      default: b = CMD_HOME_ADDR;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] adj_cmd(logic [1:0] idx, logic [CON_W-1:0] c);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = CMD_FUNC_EXT;
      2'd1:    b = CMD_PWR_ADJ | {6'd0, c[5:4]};
      2'd2:    b = CMD_CONTRAST | {4'd0, c[3:0]};
      default: b = CMD_FUNC_STD;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    return {4'd0, v} + ((v <= DIGIT_MAX) ? ASCII_ZERO : ASCII_LETTER);
  endfunction

  function automatic logic [STEP_W-1:0] last_step(kind_e k);
    logic [STEP_W-1:0] s;
    unique case (k)
      K_INIT:  s = LAST_INIT;
      K_BYTE:  s = LAST_BYTE;
      K_ADJ:   s = LAST_ADJ;
      K_HEX:   s = LAST_HEX;
      default: s = LAST_NULL;
    endcase
    return s;
  endfunction

  // nibble transfer for one step of a descriptor's run
  function automatic nib_t step_nibble(desc_t d, logic [STEP_W-1:0] step);
    nib_t r;
    logic [7:0] b;
    logic [STEP_W-1:0] s;
    logic half;
    s = step - INIT_NIBS;
    b = 8'd0;
    half = step[0];
    r.strobe = 1'b1;
    r.rs = 1'b0;
    unique case (d.kind)
      K_INIT: begin
        half = s[0];
        b = init_cmd(s[4:1], d.contrast);
      end
      K_BYTE: begin
        b = d.data;
        r.rs = d.rs;
      end
      K_ADJ: b = adj_cmd(step[2:1], d.contrast);
      K_HEX: begin
        b = hex_digit(step[1] ? d.data[3:0] : d.data[7:4]);
        r.rs = 1'b1;
      end
      default: r.strobe = 1'b0;
    endcase
    if (!r.strobe) begin
      r.nibble = '0;
    end else if (d.kind == K_INIT && step < INIT_NIBS) begin
      r.nibble = (step == INIT_NIBS - 5'd1) ? NIB_4BIT : NIB_RESET;
    end else begin
      r.nibble = half ? b[3:0] : b[7:4];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/clns_if.sv
// Valid/ready channel interfaces: action input, nibble output, register writes.
// Depends on clns_pkg for field widths.
`default_nettype none

interface clns_in_if;
  import clns_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [VALUE_W-1:0]         value;
  logic signed [OFFSET_W-1:0] offset;
  modport source (output valid, action, value, offset, input ready);
  modport sink   (input valid, action, value, offset, output ready);
endinterface

interface clns_out_if;
  import clns_pkg::*;
  logic             valid;
  logic             ready;
  logic             strobe_res;
  logic             reg_select;
  logic [NIB_W-1:0] nibble;
  logic [CON_W-1:0] contrast;
  logic             last;
  modport source (output valid, strobe_res, reg_select, nibble, contrast, last,
                  input ready);
  modport sink   (input valid, strobe_res, reg_select, nibble, contrast, last,
                  output ready);
endinterface

interface clns_cfg_if;
  import clns_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/clns_front.sv
// Front end: takes actions and register writes, holds contrast state,
// and turns each action into a run descriptor. Depends on clns_pkg, clns_if.
`default_nettype none

module clns_front (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  clns_in_if.sink      in_i,
  clns_cfg_if.sink     cfg_i,
  output logic         push_valid_o,
  input  wire logic    push_ready_i,
  output clns_pkg::desc_t desc_o
);
  import clns_pkg::*;

  logic [CON_W-1:0] max_q, max_d;
  logic [CON_W-1:0] saved_q, saved_d;
  logic [CON_W-1:0] level_q, level_d;
  logic signed [7:0] sum;
  logic [CON_W-1:0]  clamped;
  logic              accept;
  logic              cfg_wr;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;
  assign cfg_i.ready  = 1'b1;
  assign cfg_wr       = cfg_i.valid;

  always_comb begin
    sum = $signed({2'b00, level_q}) + $signed({in_i.offset[OFFSET_W-1], in_i.offset});
    if (sum > $signed({2'b00, max_q})) begin
      clamped = max_q;
    end else if (sum[7]) begin
      clamped = '0;
    end else begin
      clamped = sum[CON_W-1:0];
    end
  end

  always_comb begin
    desc_o.rs       = 1'b0;
    desc_o.data     = in_i.value;
    desc_o.contrast = level_q;
    level_d         = level_q;
    unique case (in_i.action)
      ACT_INIT: begin
        desc_o.kind     = K_INIT;
        desc_o.contrast = saved_q;
        level_d         = saved_q;
      end
      ACT_CMD:  desc_o.kind = K_BYTE;
      ACT_DATA: begin
        desc_o.kind = K_BYTE;
        desc_o.rs   = 1'b1;
      end
      ACT_ADJ: begin
        // clamp applies even when the offset is zero
        desc_o.kind     = (in_i.offset != '0) ? K_ADJ : K_NULL;
        desc_o.contrast = clamped;
        level_d         = clamped;
      end
      ACT_HEX: begin
        desc_o.kind = K_HEX;
        desc_o.rs   = 1'b1;
      end
      default: desc_o.kind = K_NULL;
    endcase
  end

  always_comb begin
    max_d   = max_q;
    saved_d = saved_q;
    if (cfg_wr) begin
      unique case (cfg_i.index)
        REG_MAX_CONTRAST:   max_d   = cfg_i.data;
        REG_SAVED_CONTRAST: saved_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= MAX_CONTRAST_RST;
      saved_q <= SAVED_CONTRAST_RST;
      level_q <= SAVED_CONTRAST_RST;
    end else begin
      max_q   <= max_d;
      saved_q <= saved_d;
      if (accept) begin
        level_q <= level_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/clns_queue.sv
// Small descriptor FIFO between the front end and the nibble sequencer.
// Depends on clns_pkg for the descriptor type.
`default_nettype none

module clns_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_valid_i,
  output logic            push_ready_o,
  input  wire clns_pkg::desc_t push_desc_i,
  output logic            pop_valid_o,
  input  wire logic       pop_ready_i,
  output clns_pkg::desc_t pop_desc_o
);
  import clns_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  desc_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_desc_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

`default_nettype wire

>>> design/clns_back.sv
// Back end: steps through a descriptor's run, one nibble word per cycle while
// out_o is taken, into a registered output. Depends on clns_pkg, clns_if.
`default_nettype none

module clns_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       pop_valid_i,
  output logic            pop_ready_o,
  input  wire clns_pkg::desc_t pop_desc_i,
  clns_out_if.source      out_o
);
  import clns_pkg::*;

  desc_t             desc_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              out_valid_q;
  nib_t              nib_q;
  logic [CON_W-1:0]  con_q;
  logic              last_q;
  nib_t              cur;
  logic              is_last;
  logic              advance;
  logic              take;

  assign cur         = step_nibble(desc_q, step_q);
  assign is_last     = step_q == last_step(desc_q.kind);
  assign advance     = busy_q && (!out_valid_q || out_o.ready);
  // load the next run in the cycle the current one issues its final word
  assign pop_ready_o = !busy_q || (advance && is_last);
  assign take        = pop_valid_i && pop_ready_o;

  assign out_o.valid      = out_valid_q;
  assign out_o.strobe_res = nib_q.strobe;
  assign out_o.reg_select = nib_q.rs;
  assign out_o.nibble     = nib_q.nibble;
  assign out_o.contrast   = con_q;
  assign out_o.last       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (advance) begin
        busy_q <= !is_last;
        step_q <= step_q + STEP_W'(1);
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      desc_q <= pop_desc_i;
    end
    if (advance) begin
      nib_q  <= cur;
      con_q  <= desc_q.contrast;
      last_q <= is_last;
    end
  end

endmodule

`default_nettype wire

>>> design/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer.
// Depends on clns_pkg, clns_if, clns_front, clns_queue, clns_back.
//
//   channel  dir  payload                                          word
//   in_i     in   action[2:0] value[7:0] offset[6:0] (signed)      one action
//   out_o    out  strobe_res reg_select nibble[3:0] contrast[5:0]  one nibble
//                 last
//   cfg_i    in   index[3:0] data[5:0]                             one write
//
// An action yields 1 to 26 output words, one per cycle while out_o is taken;
// the back-end sequencer issuing a word per cycle sets that figure.
// Actions are taken whenever the two-entry descriptor queue has room, and the
// next run starts in the cycle the previous run issues its last word.
// Output stalls back up into the queue and then into in_i; cfg_i never stalls.
// Reset clears the queue, the sequencer and the output valid at once.
`default_nettype none

module char_lcd_nibble_sequencer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  clns_in_if.sink    in_i,
  clns_cfg_if.sink   cfg_i,
  clns_out_if.source out_o
);
  import clns_pkg::*;

  logic  push_valid, push_ready;
  logic  pop_valid, pop_ready;
  desc_t push_desc, pop_desc;

  clns_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .desc_o       (push_desc)
  );

  clns_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_desc_i  (push_desc),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_desc_o   (pop_desc)
  );

  clns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_desc_i  (pop_desc),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

>>> design/clns_checker.sv
// Port-level checks on the output channel, bound to the top level.
// Depends on assert_macros.svh and clns_pkg.
`default_nettype none
`include "assert_macros.svh"

module clns_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       strobe_i,
  input wire logic       rs_i,
  input wire logic [3:0] nibble_i,
  input wire logic [5:0] contrast_i,
  input wire logic       last_i
);
  import clns_pkg::*;

  logic [NIB_W+CON_W+2:0] payload;
  assign payload = {strobe_i, rs_i, nibble_i, contrast_i, last_i};

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
               out_valid_i && $stable(payload))
  `ASSERT_IMPLIES(a_idle_is_last, clk_i, rst_ni, out_valid_i && !strobe_i, last_i)
  `ASSERT_IMPLIES(a_idle_quiet, clk_i, rst_ni, out_valid_i && !strobe_i,
                  nibble_i == '0 && !rs_i)
  `ASSERT_IMPLIES(a_data_strobed, clk_i, rst_ni, out_valid_i && rs_i, strobe_i)

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .strobe_i    (out_o.strobe_res),
  .rs_i        (out_o.reg_select),
  .nibble_i    (out_o.nibble),
  .contrast_i  (out_o.contrast),
  .last_i      (out_o.last)
);

`default_nettype wire

>>> tb/sv/tb_char_lcd_nibble_sequencer.sv
// Self-checking testbench for the character LCD nibble sequencer.
// Depends on clns_pkg, the clns_if interfaces and the char_lcd_nibble_sequencer RTL.
// A built-in predictor queues the nibble words due for each action; a checker compares them.
module tb_char_lcd_nibble_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import clns_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ACTIONS = 320;

  // action codes with no defined run
  localparam logic [ACTION_W-1:0] ACT_RSVD_A = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RSVD_B = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD_C = 3'd7;
  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic             strobe;
    logic             rs;
    logic [NIB_W-1:0] nibble;
    logic [CON_W-1:0] contrast;
    logic             last;
  } lcd_word_t;

  logic clk_i;
  logic rst_ni;

  clns_in_if  in_if();
  clns_cfg_if cfg_if();
  clns_out_if out_if();

  char_lcd_nibble_sequencer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // predictor state
  logic [CON_W-1:0] max_contrast_q   = MAX_CONTRAST_RST;
  logic [CON_W-1:0] saved_contrast_q = SAVED_CONTRAST_RST;
  logic [CON_W-1:0] contrast_lvl_q   = SAVED_CONTRAST_RST;

  lcd_word_t   words_due[$];
  lcd_word_t   word_head;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned src_idle_pct = 13;
  int unsigned sink_stall_pct = 13;
  int unsigned sink_hold = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: long hold-offs take priority over random stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        out_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  function automatic logic [7:0] ascii_hex(logic [3:0] v);
    return (v <= 4'd9) ? (ASCII_ZERO + 8'(v)) : (ASCII_LETTER + 8'(v));
  endfunction

  task automatic push_nibble(logic strobe, logic rs, logic [NIB_W-1:0] nib);
    lcd_word_t w;
    w.strobe   = strobe;
    w.rs       = rs;
    w.nibble   = nib;
    w.contrast = contrast_lvl_q;
    w.last     = 1'b0;
    words_due.push_back(w);
  endtask

  task automatic push_byte(logic [7:0] b, logic rs);
    push_nibble(1'b1, rs, b[7:4]);
    push_nibble(1'b1, rs, b[3:0]);
  endtask

  task automatic predict_action(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val,
                                logic signed [OFFSET_W-1:0] off);
    int        sum;
    lcd_word_t tail;
    case (act)
      ACT_INIT: begin
        contrast_lvl_q = saved_contrast_q;
        repeat (3) push_nibble(1'b1, 1'b0, NIB_RESET);
        push_nibble(1'b1, 1'b0, NIB_4BIT);
        push_byte(CMD_FUNC_EXT, 1'b0);
        push_byte(CMD_BIAS, 1'b0);
        push_byte(CMD_FOLLOWER, 1'b0);
        push_byte(CMD_PWR_INIT | {6'd0, contrast_lvl_q[5:4]}, 1'b0);
        push_byte(CMD_CONTRAST | {4'd0, contrast_lvl_q[3:0]}, 1'b0);
        push_byte(CMD_FUNC_STD, 1'b0);
        push_byte(CMD_DISP_OFF, 1'b0);
        push_byte(CMD_CLEAR, 1'b0);
        push_byte(CMD_ENTRY, 1'b0);
        push_byte(CMD_DISP_ON, 1'b0);
        push_byte(CMD_HOME_ADDR, 1'b0);
      end
      ACT_CMD:  push_byte(val, 1'b0);
      ACT_DATA: push_byte(val, 1'b1);
      ACT_ADJ: begin
        // clamp applies even when the offset is zero
        sum = int'(contrast_lvl_q) + int'(off);
        if (sum > int'(max_contrast_q)) sum = int'(max_contrast_q);
        if (sum < 0) sum = 0;
        contrast_lvl_q = sum[CON_W-1:0];
        if (off != 0) begin
          push_byte(CMD_FUNC_EXT, 1'b0);
          push_byte(CMD_PWR_ADJ | {6'd0, contrast_lvl_q[5:4]}, 1'b0);
          push_byte(CMD_CONTRAST | {4'd0, contrast_lvl_q[3:0]}, 1'b0);
          push_byte(CMD_FUNC_STD, 1'b0);
        end else begin
          push_nibble(1'b0, 1'b0, '0);
        end
      end
      ACT_HEX: begin
        push_byte(ascii_hex(val[7:4]), 1'b1);
        push_byte(ascii_hex(val[3:0]), 1'b1);
      end
      default: push_nibble(1'b0, 1'b0, '0);
    endcase
    tail = words_due.pop_back();
    tail.last = 1'b1;
    words_due.push_back(tail);
  endtask

  task automatic send_action(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val,
                             logic signed [OFFSET_W-1:0] off);
    @(negedge clk_i);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.action <= act;
    in_if.value  <= val;
    in_if.offset <= off;
    in_if.valid  <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    predict_action(act, val, off);
  endtask

  task automatic drop_action_valid();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  // hold until every due word has come, then let the pipeline settle
  task automatic wait_drained();
    drop_action_valid();
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] dat);
    @(negedge clk_i);
    cfg_if.index <= idx;
    cfg_if.data  <= dat;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_MAX_CONTRAST) max_contrast_q = dat;
    else if (idx == REG_SAVED_CONTRAST) saved_contrast_q = dat;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_random_action();
    int unsigned                pick;
    logic [ACTION_W-1:0]        act;
    logic signed [OFFSET_W-1:0] off;
    pick = $urandom_range(99);
    if (pick < 6) act = ACT_INIT;
    else if (pick < 24) act = ACT_CMD;
    else if (pick < 42) act = ACT_DATA;
    else if (pick < 70) act = ACT_ADJ;
    else if (pick < 95) act = ACT_HEX;
    else act = ACT_RSVD_A + ACTION_W'($urandom_range(2));
    pick = $urandom_range(9);
    if (pick == 0) off = '0;
    else if (pick == 1) off = 7'sd63;
    else if (pick == 2) off = -7'sd63;
    else off = OFFSET_W'(int'($urandom_range(126)) - 63);
    send_action(act, VALUE_W'($urandom_range(255)), off);
  endtask

  task automatic report(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (words_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual nibble %0h last %0b",
                 $time, out_if.nibble, out_if.last);
        mismatches++;
      end else begin
        word_head = words_due.pop_front();
        report("strobe_res", word_head.strobe, out_if.strobe_res);
        report("reg_select", word_head.rs, out_if.reg_select);
        report("nibble", word_head.nibble, out_if.nibble);
        report("contrast", word_head.contrast, out_if.contrast);
        report("last", word_head.last, out_if.last);
      end
    end
  end

  task automatic test_power_up();
    send_action(ACT_INIT, 8'h00, '0);
    wait_drained();
  endtask

  task automatic test_byte_transfers();
    send_action(ACT_CMD, 8'h00, 7'sd63);
    send_action(ACT_CMD, 8'hFF, -7'sd63);
    send_action(ACT_DATA, 8'h00, '0);
    send_action(ACT_DATA, 8'hFF, 7'sd1);
    send_action(ACT_HEX, 8'h00, '0);
    send_action(ACT_HEX, 8'h9A, '0);
    send_action(ACT_HEX, 8'hA9, '0);
    send_action(ACT_HEX, 8'hFF, '0);
    wait_drained();
  endtask

  task automatic test_contrast_adjust();
    send_action(ACT_ADJ, 8'hFF, 7'sd63);
    send_action(ACT_ADJ, 8'h00, -7'sd63);
    send_action(ACT_ADJ, 8'h55, '0);
    send_action(ACT_ADJ, 8'hAA, 7'sd1);
    send_action(ACT_ADJ, 8'h00, -7'sd1);
    send_action(ACT_ADJ, 8'h00, 7'sd20);
    wait_drained();
  endtask

  task automatic test_unused_actions();
    send_action(ACT_RSVD_A, 8'hFF, 7'sd63);
    send_action(ACT_RSVD_B, 8'h00, -7'sd63);
    send_action(ACT_RSVD_C, 8'h5A, '0);
    wait_drained();
  endtask

  task automatic test_register_writes();
    write_reg(REG_MAX_CONTRAST, 6'd0);
    write_reg(REG_SAVED_CONTRAST, 6'd0);
    // undecoded indexes must leave both registers alone
    write_reg(REG_UNUSED_LO, 6'd63);
    write_reg(REG_UNUSED_HI, 6'd63);
    send_action(ACT_INIT, 8'h00, '0);
    send_action(ACT_ADJ, 8'h00, 7'sd5);
    wait_drained();
    write_reg(REG_MAX_CONTRAST, 6'd63);
    write_reg(REG_SAVED_CONTRAST, 6'd63);
    send_action(ACT_INIT, 8'h00, '0);
    wait_drained();
    // level sits above the new max: a zero offset still pulls it down
    write_reg(REG_MAX_CONTRAST, 6'd10);
    send_action(ACT_ADJ, 8'h00, '0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    sink_hold = 400;
    src_idle_pct = 0;
    repeat (24) send_random_action();
    src_idle_pct = 13;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_MAX_CONTRAST, 6'd63);
          write_reg(REG_SAVED_CONTRAST, 6'd0);
        end
        1: begin
          write_reg(REG_MAX_CONTRAST, 6'd0);
          write_reg(REG_SAVED_CONTRAST, 6'd63);
        end
        2: begin
          write_reg(REG_MAX_CONTRAST, 6'd63);
          write_reg(REG_SAVED_CONTRAST, 6'd63);
        end
        default: begin
          write_reg(REG_MAX_CONTRAST, CFG_DAT_W'($urandom_range(63)));
          write_reg(REG_SAVED_CONTRAST, CFG_DAT_W'($urandom_range(63)));
        end
      endcase
      // one phase runs with no idling on either side
      src_idle_pct = (phase == 2) ? 0 : 13;
      sink_stall_pct = (phase == 2) ? 0 : 13;
      repeat (RANDOM_ACTIONS / 4) send_random_action();
      wait_drained();
    end
    src_idle_pct = 13;
    sink_stall_pct = 13;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = ACT_INIT;
    in_if.value = '0;
    in_if.offset = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_MAX_CONTRAST;
    cfg_if.data = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_power_up();
    test_byte_transfers();
    test_contrast_adjust();
    test_unused_actions();
    test_register_writes();
    test_backpressure();
    test_random_traffic();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> char_lcd_nibble_sequencer.f
+incdir+design
design/clns_pkg.sv
design/clns_if.sv
design/clns_front.sv
design/clns_queue.sv
design/clns_back.sv
design/char_lcd_nibble_sequencer.sv
design/clns_checker.sv
tb/sv/tb_char_lcd_nibble_sequencer.sv
